// ----- src/u8sd_pkg.sv -----
// Shared type (cmd_t), constants and function (seq_is_bad) for the UTF-8 stream decoder.
package u8sd_pkg;

    localparam int CP_W        = 31;
    localparam int USED_W      = 3;
    localparam int CNT_W       = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

    localparam logic [CP_W-1:0] REPL_RESET = 31'h0000_FFFD;

    localparam logic [7:0] CONT_MASK = 8'hC0;
    localparam logic [7:0] CONT_TAG  = 8'h80;
    localparam logic [7:0] LEAD_MIN  = 8'hC0;
    localparam logic [7:0] LEAD_MAX  = 8'hFD;
    localparam logic [7:0] ASCII_LIM = 8'h80;

    localparam logic [CP_W-1:0] MIN_LEN2  = 31'h0000_0080;
    localparam logic [CP_W-1:0] MIN_LEN3  = 31'h0000_0800;
    localparam logic [CP_W-1:0] MIN_LEN4  = 31'h0001_0000;
    localparam logic [CP_W-1:0] MIN_LEN5  = 31'h0020_0000;
    localparam logic [CP_W-1:0] MIN_LEN6  = 31'h0400_0000;
    localparam logic [CP_W-1:0] SURR_LO   = 31'h0000_D800;
    localparam logic [CP_W-1:0] SURR_HI   = 31'h0000_DFFF;
    localparam logic [CP_W-1:0] NONCHAR_E = 31'h0000_FFFE;
    localparam logic [CP_W-1:0] NONCHAR_F = 31'h0000_FFFF;

    typedef struct packed {
        logic [CNT_W-1:0]  rep_cnt;
        logic              mid_valid;
        logic [CP_W-1:0]   mid_cp;
        logic [USED_W-1:0] mid_used;
        logic              mid_bad;
    } cmd_t;

    function automatic logic seq_is_bad(input logic [CP_W-1:0] v,
                                        input logic [USED_W-1:0] len);
        logic bad;
        bad = 1'b0;
        if (len > 3'd1 && v < MIN_LEN2) bad = 1'b1;
        if (len > 3'd2 && v < MIN_LEN3) bad = 1'b1;
        if (len > 3'd3 && v < MIN_LEN4) bad = 1'b1;
        if (len > 3'd4 && v < MIN_LEN5) bad = 1'b1;
        if (len > 3'd5 && v < MIN_LEN6) bad = 1'b1;
        if ((v >= SURR_LO && v <= SURR_HI) || v == NONCHAR_E || v == NONCHAR_F) bad = 1'b1;
        return bad;
    endfunction

endpackage

// ----- src/utf8_stream_decoder.sv -----
// Top level of the UTF-8 stream decoder: front end, command queue, result sequencer.
// A result passes through the command queue and then the sequencer's output register.
// Throughput: one byte per cycle while m_tready holds and each byte yields at most one result;
// a byte yielding several results holds the single output register until all of them are sent.
// Reset (aresetn low, synchronous): clears the open sequence, the queue and the output,
// and sets replacement_code to 0xFFFD.
module utf8_stream_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [30:0] cfg_wr_data,    // replacement_code
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,        // data_byte[7:0]
    input  logic        s_tlast,        // end_of_stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,        // code_point[30:0], bytes_used[33:31], zero pad
    output logic        m_tuser,        // malformed
    output logic        m_tlast         // last
);

    logic [u8sd_pkg::CP_W-1:0]   repl_reg;
    logic                        in_fire;
    logic                        q_push, q_pop, q_empty, q_full;
    u8sd_pkg::cmd_t              front_cmd, head_cmd;
    logic [u8sd_pkg::CP_W-1:0]   out_cp;
    logic [u8sd_pkg::USED_W-1:0] out_used;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            repl_reg <= u8sd_pkg::REPL_RESET;
        end else if (cfg_wr_en) begin
            repl_reg <= cfg_wr_data;
        end
    end

    assign s_tready = !q_full;
    assign in_fire  = s_tvalid && s_tready;

    u8sd_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (in_fire),
        .in_byte (s_tdata),
        .in_eos  (s_tlast),
        .repl    (repl_reg),
        .push    (q_push),
        .cmd     (front_cmd)
    );

    u8sd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (front_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .empty    (q_empty),
        .full     (q_full)
    );

    u8sd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_cmd  (head_cmd),
        .q_empty   (q_empty),
        .repl      (repl_reg),
        .out_ready (m_tready),
        .pop       (q_pop),
        .out_valid (m_tvalid),
        .out_cp    (out_cp),
        .out_used  (out_used),
        .out_bad   (m_tuser),
        .out_last  (m_tlast)
    );

    assign m_tdata = {6'd0, out_used, out_cp};

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_push && q_full))
        else $error("command pushed into a full queue");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_no_overlong: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser && m_tdata[33:31] > 3'd1) |-> (m_tdata[30:0] >= 31'h80))
        else $error("overlong sequence passed as well formed");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty)
        else $error("sequencer popped an empty queue");

endmodule

// ----- src/u8sd_front.sv -----
// Front end: tracks the open sequence and turns each byte into a command, pushed only if it holds a result.
module u8sd_front (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_fire,
    input  logic [7:0]               in_byte,
    input  logic                     in_eos,
    input  logic [u8sd_pkg::CP_W-1:0] repl,
    output logic                     push,
    output u8sd_pkg::cmd_t           cmd
);

    logic [u8sd_pkg::USED_W-1:0] seq_len_reg, seq_len_next;
    logic [u8sd_pkg::CNT_W-1:0]  bcnt_reg, bcnt_next;
    logic [u8sd_pkg::CP_W-1:0]   partial_reg, partial_next;

    logic                        is_cont;
    logic [u8sd_pkg::CP_W-1:0]   acc;
    logic [u8sd_pkg::CNT_W-1:0]  bc1;
    logic [u8sd_pkg::CNT_W-1:0]  rep_pre;

    always_comb begin
        is_cont = (in_byte & u8sd_pkg::CONT_MASK) == u8sd_pkg::CONT_TAG;
        acc     = {partial_reg[u8sd_pkg::CP_W-7:0], in_byte[5:0]};
        bc1     = bcnt_reg + 3'd1;
        rep_pre = (seq_len_reg != 3'd0) ? bcnt_reg : 3'd0;

        seq_len_next  = seq_len_reg;
        bcnt_next     = bcnt_reg;
        partial_next  = partial_reg;
        cmd           = '0;

        if (seq_len_reg != 3'd0 && is_cont) begin
            if (bc1 >= seq_len_reg) begin
                cmd.mid_valid = 1'b1;
                cmd.mid_used  = seq_len_reg;
                if (u8sd_pkg::seq_is_bad(acc, seq_len_reg)) begin
                    cmd.mid_cp  = repl;
                    cmd.mid_bad = 1'b1;
                end else begin
                    cmd.mid_cp  = acc;
                    cmd.mid_bad = 1'b0;
                end
                seq_len_next = 3'd0;
                bcnt_next    = 3'd0;
                partial_next = '0;
            end else if (in_eos) begin
                cmd.rep_cnt  = bc1;
                seq_len_next = 3'd0;
                bcnt_next    = 3'd0;
                partial_next = '0;
            end else begin
                bcnt_next    = bc1;
                partial_next = acc;
            end
        end else begin
            cmd.rep_cnt  = rep_pre;
            seq_len_next = 3'd0;
            bcnt_next    = 3'd0;
            partial_next = '0;
            if (in_byte < u8sd_pkg::ASCII_LIM) begin
                cmd.mid_valid = 1'b1;
                cmd.mid_cp    = {23'd0, in_byte};
                cmd.mid_used  = 3'd1;
                cmd.mid_bad   = 1'b0;
            end else if (in_byte < u8sd_pkg::LEAD_MIN || in_byte > u8sd_pkg::LEAD_MAX) begin
                cmd.mid_valid = 1'b1;
                cmd.mid_cp    = repl;
                cmd.mid_used  = 3'd1;
                cmd.mid_bad   = 1'b1;
            end else if (in_eos) begin
                cmd.rep_cnt = rep_pre + 3'd1;
            end else begin
                bcnt_next = 3'd1;
                if ((in_byte & 8'hE0) == 8'hC0) begin
                    seq_len_next = 3'd2;
                    partial_next = {26'd0, in_byte[4:0]};
                end else if ((in_byte & 8'hF0) == 8'hE0) begin
                    seq_len_next = 3'd3;
                    partial_next = {27'd0, in_byte[3:0]};
                end else if ((in_byte & 8'hF8) == 8'hF0) begin
                    seq_len_next = 3'd4;
                    partial_next = {28'd0, in_byte[2:0]};
                end else if ((in_byte & 8'hFC) == 8'hF8) begin
                    seq_len_next = 3'd5;
                    partial_next = {29'd0, in_byte[1:0]};
                end else begin
                    seq_len_next = 3'd6;
                    partial_next = {30'd0, in_byte[0]};
                end
            end
        end

        push = in_fire && (cmd.rep_cnt != 3'd0 || cmd.mid_valid);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_len_reg <= '0;
            bcnt_reg    <= '0;
            partial_reg <= '0;
        end else if (in_fire) begin
            seq_len_reg <= seq_len_next;
            bcnt_reg    <= bcnt_next;
            partial_reg <= partial_next;
        end
    end

endmodule

// ----- src/u8sd_queue.sv -----
// Short command queue between the front end and the result sequencer.
module u8sd_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  u8sd_pkg::cmd_t push_cmd,
    input  logic           pop,
    output u8sd_pkg::cmd_t head_cmd,
    output logic           empty,
    output logic           full
);

    u8sd_pkg::cmd_t mem [u8sd_pkg::QUEUE_DEPTH];

    logic [u8sd_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [u8sd_pkg::QUEUE_CNT_W-1:0] count_reg;
    logic                             do_push, do_pop;

    assign empty    = count_reg == '0;
    assign full     = count_reg == u8sd_pkg::QUEUE_CNT_W'(u8sd_pkg::QUEUE_DEPTH);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_cmd = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ----- src/u8sd_back.sv -----
// Result sequencer: expands each command into result items into an output register.
module u8sd_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  u8sd_pkg::cmd_t               head_cmd,
    input  logic                         q_empty,
    input  logic [u8sd_pkg::CP_W-1:0]    repl,
    input  logic                         out_ready,
    output logic                         pop,
    output logic                         out_valid,
    output logic [u8sd_pkg::CP_W-1:0]    out_cp,
    output logic [u8sd_pkg::USED_W-1:0]  out_used,
    output logic                         out_bad,
    output logic                         out_last
);

    logic [u8sd_pkg::CNT_W-1:0]  idx_reg, idx_next;
    logic                        valid_reg;
    logic [u8sd_pkg::CP_W-1:0]   cp_reg;
    logic [u8sd_pkg::USED_W-1:0] used_reg;
    logic                        bad_reg, last_reg;

    logic                        load;
    logic                        in_reps;
    logic [u8sd_pkg::CP_W-1:0]   cp_next;
    logic [u8sd_pkg::USED_W-1:0] used_next;
    logic                        bad_next, last_next;

    always_comb begin
        load    = !q_empty && (!valid_reg || out_ready);
        in_reps = idx_reg < head_cmd.rep_cnt;
        pop     = 1'b0;
        idx_next = idx_reg;
        if (in_reps) begin
            cp_next   = repl;
            used_next = 3'd1;
            bad_next  = 1'b1;
            last_next = (idx_reg + 3'd1 == head_cmd.rep_cnt) && !head_cmd.mid_valid;
        end else begin
            cp_next   = head_cmd.mid_cp;
            used_next = head_cmd.mid_used;
            bad_next  = head_cmd.mid_bad;
            last_next = 1'b1;
        end
        if (load) begin
            if (last_next) begin
                pop      = 1'b1;
                idx_next = 3'd0;
            end else begin
                idx_next = idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            idx_reg <= idx_next;
            if (load) begin
                valid_reg <= 1'b1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            cp_reg   <= cp_next;
            used_reg <= used_next;
            bad_reg  <= bad_next;
            last_reg <= last_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_cp    = cp_reg;
    assign out_used  = used_reg;
    assign out_bad   = bad_reg;
    assign out_last  = last_reg;

endmodule
